// File: src/gaps_pkg.sv
// Shared types, codes and constants of the grid A* path search unit.
// Used by the cost unit and the top level.
package gaps_pkg;

    localparam int unsigned NCELL = 64;     // 8 x 8 addressable cells
    localparam logic [3:0] STEP_STRAIGHT = 4'd10;
    localparam logic [3:0] STEP_DIAG     = 4'd14;

    typedef enum logic [1:0] {
        ST_WRITE_DONE = 2'd0,
        ST_PATH_STEP  = 2'd1,
        ST_NO_PATH    = 2'd2
    } t_status;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_FIND  = 1'b1
    } t_req;

    typedef enum logic {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_INIT   = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_PICK   = 11'b000_0000_1000,
        S_NB_CHK = 11'b000_0001_0000,
        S_NB_UPD = 11'b000_0010_0000,
        S_TR_RD  = 11'b000_0100_0000,
        S_TR_NX  = 11'b000_1000_0000,
        S_EM_RD  = 11'b001_0000_0000,
        S_EM_LD  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    // One node record: insertion order, parent direction, f and g costs.
    typedef struct packed {
        logic [6:0]  order;
        logic [2:0]  parent;
        logic [10:0] total;
        logic [9:0]  cost;
    } t_node;

    typedef struct packed {
        logic [9:0] base_cost;
        logic [2:0] dir;
        logic [2:0] nx;
        logic [2:0] ny;
        logic [2:0] gx;
        logic [2:0] gy;
        logic [9:0] old_cost;
    } t_cost_req;

    typedef struct packed {
        logic [9:0]  cost;
        logic [10:0] total;
        logic        better;
    } t_cost_rsp;

    // Neighbor order W, E, N, S, NW, SE, NE, SW; offsets in 4-bit two's complement.
    function automatic logic [3:0] f_dx(input logic [2:0] d);
        logic [3:0] r;
        case (d)
            3'd0, 3'd4, 3'd7: r = 4'hF;
            3'd1, 3'd5, 3'd6: r = 4'h1;
            default:          r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] f_dy(input logic [2:0] d);
        logic [3:0] r;
        case (d)
            3'd2, 3'd4, 3'd6: r = 4'hF;
            3'd3, 3'd5, 3'd7: r = 4'h1;
            default:          r = 4'h0;
        endcase
        return r;
    endfunction

endpackage

// File: src/gaps_req_if.sv
// Request channel of the grid A* path search unit: valid/ready plus item fields.
// Depends on nothing.
interface gaps_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       cell_blocked;
    logic [2:0] start_x;
    logic [2:0] start_y;
    logic [2:0] goal_x;
    logic [2:0] goal_y;

    modport source (output valid, req_type, cell_x, cell_y, cell_blocked,
                     start_x, start_y, goal_x, goal_y, input ready);
    modport sink   (input valid, req_type, cell_x, cell_y, cell_blocked,
                     start_x, start_y, goal_x, goal_y, output ready);
endinterface

// File: src/gaps_rsp_if.sv
// Result channel of the grid A* path search unit: valid/ready plus item fields.
// Depends on nothing.
interface gaps_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic       last;

    modport source (output valid, status, step_x, step_y, last, input ready);
    modport sink   (input valid, status, step_x, step_y, last, output ready);
endinterface

// File: src/gaps_cost_unit.sv
// Shared cost unit: g of a neighbor, its f with the Manhattan heuristic, and
// whether it beats the stored g. Depends on gaps_pkg.
module gaps_cost_unit
    import gaps_pkg::*;
(
    input  t_cost_req i_req,
    output t_cost_rsp o_rsp
);
    logic [2:0]  ddx, ddy;
    logic [3:0]  manh;
    logic [7:0]  heur;
    logic [10:0] ng;
    logic [10:0] tot;

    always_comb begin
        ddx  = (i_req.nx > i_req.gx) ? i_req.nx - i_req.gx : i_req.gx - i_req.nx;
        ddy  = (i_req.ny > i_req.gy) ? i_req.ny - i_req.gy : i_req.gy - i_req.ny;
        manh = {1'b0, ddx} + {1'b0, ddy};
        heur = {1'b0, manh, 3'b000} + {3'b000, manh, 1'b0};
        ng   = {1'b0, i_req.base_cost}
             + {7'd0, (i_req.dir[2] ? STEP_DIAG : STEP_STRAIGHT)};
        tot  = ng + {3'd0, heur};
        o_rsp.cost   = ng[9:0];
        o_rsp.total  = tot;
        o_rsp.better = ng < {1'b0, i_req.old_cost};
    end
endmodule

// File: src/grid_astar_path_search_unit.sv
// Grid A* path search unit: top level with sequencer, cell flags and node memory.
// Depends on gaps_pkg, gaps_req_if, gaps_rsp_if and gaps_cost_unit.
//
// Usage: items enter on i_req (valid/ready). A write item (req_type 0) sets one
// cell's blocked bit and returns one item with status 0. A find item (req_type 1)
// runs 8-connected A* inside the map_width x map_height area and returns the
// path from start (excluded) to goal, one item per cell, last set on the goal;
// or a single no-path item. Results leave on o_rsp from one output register.
// map_width/map_height are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while the unit is idle, as the unit does not enforce it.
// i_req.ready is high only while the unit is idle. Timing: a write or rejected
// find has its result registered in the next cycle. A search scans the open set
// for its minimum (one node memory read per cycle over all 64 cells), checks the 8
// neighbors, then traces the path back (read, parent step) and emits each cell.
// Reset: the blocked map is cleared, map size returns to 8 x 8, the unit idles.
// A stalled receiver holds the current result; the sequencer waits on it.
module grid_astar_path_search_unit
    import gaps_pkg::*;
#(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    gaps_req_if.sink   i_req,
    gaps_rsp_if.source o_rsp
);
    localparam int LIM_W = (GRID_COLS < 8) ? GRID_COLS : 8;
    localparam int LIM_H = (GRID_ROWS < 8) ? GRID_ROWS : 8;

    t_state r_state, n_state;

    logic [3:0]  r_cfg_w, r_cfg_h;
    logic [3:0]  eff_w, eff_h;
    logic [63:0] r_blocked, r_open, r_closed;

    t_node       r_node_mem [NCELL];
    t_node       r_node_q;
    logic        node_we;
    logic [5:0]  node_waddr, node_raddr;
    t_node       node_wdata;

    logic [5:0]  r_stk_mem [NCELL];
    logic [5:0]  r_stk_q;
    logic        stk_we;
    logic [5:0]  stk_raddr;

    logic [2:0]  r_sx, r_sy, r_gx, r_gy;
    logic [6:0]  r_cnt;
    logic        r_pv;
    logic [5:0]  r_pidx;
    logic        r_have;
    logic [5:0]  r_best;
    logic [10:0] r_best_total;
    logic [6:0]  r_best_order;
    logic [9:0]  r_best_cost;
    logic [2:0]  r_dir;
    logic [5:0]  r_nc;
    logic [2:0]  r_nx, r_ny;
    logic [6:0]  r_order;
    logic [5:0]  r_cur;
    logic [6:0]  r_n;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [2:0]  r_out_x, r_out_y;
    logic        r_out_last;

    logic        acc;
    logic        find_ok;
    logic        scan_better;
    logic [3:0]  nx4, ny4;
    logic        nb_ok;
    logic [5:0]  nb_idx;
    logic [3:0]  tr_dx, tr_dy;
    logic [2:0]  tr_px, tr_py;
    t_cost_req   cu_req;
    t_cost_rsp   cu_rsp;

    gaps_cost_unit u_cost (.i_req(cu_req), .o_rsp(cu_rsp));

    // Clamp the map size to the usable range.
    always_comb begin
        if (r_cfg_w == 4'd0)           eff_w = 4'd1;
        else if (int'(r_cfg_w) > LIM_W) eff_w = 4'(LIM_W);
        else                           eff_w = r_cfg_w;
        if (r_cfg_h == 4'd0)           eff_h = 4'd1;
        else if (int'(r_cfg_h) > LIM_H) eff_h = 4'(LIM_H);
        else                           eff_h = r_cfg_h;
    end

    assign acc = i_req.valid && i_req.ready;
    assign i_req.ready = r_state == S_IDLE;

    assign find_ok = ({1'b0, i_req.start_x} < eff_w) && ({1'b0, i_req.start_y} < eff_h)
                  && ({1'b0, i_req.goal_x} < eff_w) && ({1'b0, i_req.goal_y} < eff_h)
                  && ({i_req.start_y, i_req.start_x} != {i_req.goal_y, i_req.goal_x})
                  && !r_blocked[{i_req.goal_y, i_req.goal_x}];

    assign scan_better = !r_have || (r_node_q.total < r_best_total)
                      || ((r_node_q.total == r_best_total) && (r_node_q.order < r_best_order));

    // Neighbor of the expanded cell; a step off the left or top wraps to 4'hF.
    assign nx4    = {1'b0, r_best[2:0]} + f_dx(r_dir);
    assign ny4    = {1'b0, r_best[5:3]} + f_dy(r_dir);
    assign nb_ok  = (nx4 < eff_w) && (ny4 < eff_h);
    assign nb_idx = {ny4[2:0], nx4[2:0]};

    assign tr_dx = f_dx(r_node_q.parent);
    assign tr_dy = f_dy(r_node_q.parent);
    assign tr_px = r_cur[2:0] - tr_dx[2:0];
    assign tr_py = r_cur[5:3] - tr_dy[2:0];

    always_comb begin
        cu_req.base_cost = r_best_cost;
        cu_req.dir       = r_dir;
        cu_req.nx        = r_nx;
        cu_req.ny        = r_ny;
        cu_req.gx        = r_gx;
        cu_req.gy        = r_gy;
        cu_req.old_cost  = r_node_q.cost;
    end

    // Node memory port control.
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_nc;
        node_wdata = '0;
        unique case (r_state)
            S_NB_CHK: node_raddr = nb_idx;
            S_TR_RD:  node_raddr = r_cur;
            default:  node_raddr = r_cnt[5:0];
        endcase
        if (r_state == S_INIT) begin
            node_we    = 1'b1;
            node_waddr = {r_sy, r_sx};
        end else if (r_state == S_NB_UPD) begin
            if (r_open[r_nc]) begin
                node_we    = cu_rsp.better;
                node_wdata = '{order: r_node_q.order, parent: r_dir,
                               total: cu_rsp.total, cost: cu_rsp.cost};
            end else begin
                node_we    = !r_blocked[r_nc];
                node_wdata = '{order: r_order, parent: r_dir,
                               total: cu_rsp.total, cost: cu_rsp.cost};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) r_node_mem[node_waddr] <= node_wdata;
        r_node_q <= r_node_mem[node_raddr];
    end

    assign stk_we    = (r_state == S_TR_RD) && (r_cur != {r_sy, r_sx});
    assign stk_raddr = r_n[5:0] - 6'd1;

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[r_n[5:0]] <= r_cur;
        r_stk_q <= r_stk_mem[stk_raddr];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (acc) n_state = (i_req.req_type == REQ_FIND && find_ok) ? S_INIT : S_OUT;
            S_INIT:   n_state = S_SCAN;
            S_SCAN:   if (r_cnt == 7'd64) n_state = S_PICK;
            S_PICK: begin
                if (!r_have)                      n_state = S_OUT;
                else if (r_best == {r_gy, r_gx})  n_state = S_TR_RD;
                else                              n_state = S_NB_CHK;
            end
            S_NB_CHK: begin
                if (nb_ok && !r_closed[nb_idx]) n_state = S_NB_UPD;
                else if (r_dir == 3'd7)         n_state = S_SCAN;
            end
            S_NB_UPD: n_state = (r_dir == 3'd7) ? S_SCAN : S_NB_CHK;
            S_TR_RD:  n_state = (r_cur == {r_sy, r_sx}) ? S_EM_RD : S_TR_NX;
            S_TR_NX:  n_state = S_TR_RD;
            S_EM_RD:  n_state = S_EM_LD;
            S_EM_LD:  n_state = S_OUT;
            S_OUT:    if (o_rsp.ready) n_state = r_out_last ? S_IDLE : S_EM_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= 4'd8;
            r_cfg_h     <= 4'd8;
            r_blocked   <= '0;
            r_open      <= '0;
            r_closed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAP_WIDTH) r_cfg_w <= i_cfg_data;
                else                            r_cfg_h <= i_cfg_data;
            end

            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_sx <= i_req.start_x;
                    r_sy <= i_req.start_y;
                    r_gx <= i_req.goal_x;
                    r_gy <= i_req.goal_y;
                    r_out_x    <= 3'd0;
                    r_out_y    <= 3'd0;
                    r_out_last <= 1'b1;
                    if (i_req.req_type == REQ_WRITE) begin
                        if ((int'(i_req.cell_x) < GRID_COLS) && (int'(i_req.cell_y) < GRID_ROWS))
                            r_blocked[{i_req.cell_y, i_req.cell_x}] <= i_req.cell_blocked;
                        r_out_status <= ST_WRITE_DONE;
                        r_out_valid  <= 1'b1;
                    end else if (!find_ok) begin
                        r_out_status <= ST_NO_PATH;
                        r_out_valid  <= 1'b1;
                    end
                end
                S_INIT: begin
                    // open only the start cell
                    r_open   <= 64'd1 << {r_sy, r_sx};
                    r_closed <= '0;
                    r_order  <= 7'd1;
                    r_cnt    <= '0;
                    r_pv     <= 1'b0;
                    r_have   <= 1'b0;
                end
                S_SCAN: begin
                    r_cnt  <= r_cnt + 7'd1;
                    r_pv   <= !r_cnt[6] && r_open[r_cnt[5:0]];
                    r_pidx <= r_cnt[5:0];
                    if (r_pv && scan_better) begin
                        r_have       <= 1'b1;
                        r_best       <= r_pidx;
                        r_best_total <= r_node_q.total;
                        r_best_order <= r_node_q.order;
                        r_best_cost  <= r_node_q.cost;
                    end
                end
                S_PICK: begin
                    r_dir <= 3'd0;
                    r_cur <= {r_gy, r_gx};
                    r_n   <= '0;
                    if (r_have) begin
                        r_open[r_best]   <= 1'b0;
                        r_closed[r_best] <= 1'b1;
                    end else begin
                        r_out_status <= ST_NO_PATH;
                        r_out_x      <= 3'd0;
                        r_out_y      <= 3'd0;
                        r_out_last   <= 1'b1;
                        r_out_valid  <= 1'b1;
                    end
                end
                S_NB_CHK: begin
                    r_nc <= nb_idx;
                    r_nx <= nx4[2:0];
                    r_ny <= ny4[2:0];
                    if (!(nb_ok && !r_closed[nb_idx])) begin
                        r_dir <= r_dir + 3'd1;
                        r_cnt  <= '0;
                        r_pv   <= 1'b0;
                        r_have <= 1'b0;
                    end
                end
                S_NB_UPD: begin
                    if (!r_open[r_nc] && !r_blocked[r_nc]) begin
                        r_open[r_nc] <= 1'b1;
                        r_order      <= r_order + 7'd1;
                    end
                    r_dir  <= r_dir + 3'd1;
                    r_cnt  <= '0;
                    r_pv   <= 1'b0;
                    r_have <= 1'b0;
                end
                S_TR_RD: if (stk_we) r_n <= r_n + 7'd1;
                S_TR_NX: r_cur <= {tr_py, tr_px};
                S_EM_RD: ;
                S_EM_LD: begin
                    r_out_status <= ST_PATH_STEP;
                    r_out_x      <= r_stk_q[2:0];
                    r_out_y      <= r_stk_q[5:3];
                    r_out_last   <= r_n == 7'd1;
                    r_out_valid  <= 1'b1;
                    r_n          <= r_n - 7'd1;
                end
                S_OUT: if (o_rsp.ready) r_out_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.step_x = r_out_x;
    assign o_rsp.step_y = r_out_y;
    assign o_rsp.last   = r_out_last;

endmodule
